>>> design/kpsd_pkg.sv
// ----------------------------------------------------------------------------
// kpsd_pkg: shared types and constants for the keypad scan/debounce core
// Holds the item and result structs, the history constants, the column
// decoder and the key character table.
// ----------------------------------------------------------------------------
package kpsd_pkg;

    localparam int unsigned ROWS     = 4;
    localparam int unsigned COL_BITS = 3;

    localparam logic [15:0] HISTORY_FORCE = 16'hFE00;
    localparam logic [15:0] HISTORY_EVENT = 16'hFF00;

    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic                                fire;
        logic                                mode;
        logic [ROWS-1:0][COL_BITS-1:0]       cols;
    } kpsd_item_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       key_waiting;
        logic       key_missed;
    } kpsd_result_t;

    // One-hot column reading to column index; anything else maps to the
    // empty column.
    function automatic logic [1:0] decode_column(input logic [COL_BITS-1:0] raw);
        logic [1:0] col;
        case (raw)
            3'd1:    col = 2'd2;
            3'd2:    col = 2'd1;
            3'd4:    col = 2'd0;
            default: col = 2'd3;
        endcase
        return col;
    endfunction

    function automatic logic [7:0] key_char(input logic [1:0] row, input logic [1:0] col);
        logic [7:0] ch;
        case ({row, col})
            4'b00_00: ch = 8'h31;   // 1
            4'b00_01: ch = 8'h32;   // 2
            4'b00_10: ch = 8'h33;   // 3
            4'b01_00: ch = 8'h34;   // 4
            4'b01_01: ch = 8'h35;   // 5
            4'b01_10: ch = 8'h36;   // 6
            4'b10_00: ch = 8'h37;   // 7
            4'b10_01: ch = 8'h38;   // 8
            4'b10_10: ch = 8'h39;   // 9
            4'b11_00: ch = 8'h2A;   // *
            4'b11_01: ch = 8'h30;   // 0
            4'b11_10: ch = 8'h23;   // #
            default:  ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> design/kpsd_engine.sv
// ----------------------------------------------------------------------------
// kpsd_engine: debounce history, key capture and latch
// Holds the scanner state and forms the result of one item combinationally;
// the state advances on every item transfer.
// ----------------------------------------------------------------------------
module kpsd_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kpsd_pkg::kpsd_item_t   item,
    output kpsd_pkg::kpsd_result_t result
);
    import kpsd_pkg::*;

    logic [15:0]         press_history_reg, press_history_next;
    logic [1:0]          raw_row_reg, raw_row_next;
    logic [COL_BITS-1:0] raw_columns_reg, raw_columns_next;
    logic [1:0]          held_row_reg, held_row_next;
    logic [1:0]          held_column_reg, held_column_next;
    logic                ready_flag_reg, ready_flag_next;
    logic                missed_flag_reg, missed_flag_next;
    logic [COL_BITS-1:0] cols_any;
    logic                press_event;
    logic [7:0]          code;

    always_comb
    begin
        press_history_next = press_history_reg;
        raw_row_next       = raw_row_reg;
        raw_columns_next   = raw_columns_reg;
        held_row_next      = held_row_reg;
        held_column_next   = held_column_reg;
        ready_flag_next    = ready_flag_reg;
        missed_flag_next   = missed_flag_reg;
        code               = 8'h00;

        cols_any = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            cols_any = cols_any | item.cols[r];
        end
        press_event = (({press_history_reg[14:0], 1'b0} | {13'd0, cols_any} | HISTORY_FORCE)
                      == HISTORY_EVENT);

        if (item.mode == MODE_SCAN)
        begin
            press_history_next = {press_history_reg[14:0], 1'b0} | {13'd0, cols_any}
                                 | HISTORY_FORCE;
            // highest row with any column set wins
            for (int r = 0; r < ROWS; r++)
            begin
                if (item.cols[r] != '0)
                begin
                    raw_row_next     = 2'(r);
                    raw_columns_next = item.cols[r];
                end
            end
            if (press_event)
            begin
                if (ready_flag_reg)
                begin
                    missed_flag_next = 1'b1;
                end
                else
                begin
                    ready_flag_next  = 1'b1;
                    held_row_next    = raw_row_next;
                    held_column_next = decode_column(raw_columns_next);
                end
            end
        end
        else if (ready_flag_reg)
        begin
            ready_flag_next = 1'b0;
            code            = key_char(held_row_reg, held_column_reg);
        end
    end

    assign result.key_code    = code;
    assign result.key_waiting = ready_flag_next;
    assign result.key_missed  = missed_flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_history_reg <= '0;
            raw_row_reg       <= '0;
            raw_columns_reg   <= '0;
            held_row_reg      <= '0;
            held_column_reg   <= '0;
            ready_flag_reg    <= 1'b0;
            missed_flag_reg   <= 1'b0;
        end
        else if (item.fire)
        begin
            press_history_reg <= press_history_next;
            raw_row_reg       <= raw_row_next;
            raw_columns_reg   <= raw_columns_next;
            held_row_reg      <= held_row_next;
            held_column_reg   <= held_column_next;
            ready_flag_reg    <= ready_flag_next;
            missed_flag_reg   <= missed_flag_next;
        end
    end

    a_missed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        missed_flag_reg |=> missed_flag_reg)
        else $error("missed flag dropped");

    a_event_latches: assert property (@(posedge clk) disable iff (!rst_n)
        item.fire && item.mode == MODE_SCAN && press_event && !ready_flag_reg
        |=> ready_flag_reg)
        else $error("press event did not latch a key");

    a_held_key_kept: assert property (@(posedge clk) disable iff (!rst_n)
        item.fire && item.mode == MODE_SCAN && ready_flag_reg
        |=> held_row_reg == $past(held_row_reg) && held_column_reg == $past(held_column_reg))
        else $error("held key changed while waiting");

endmodule

>>> design/keypad_scan_debounce_latch_core.sv
// ----------------------------------------------------------------------------
// keypad_scan_debounce_latch_core: 4x3 keypad scanner with shift debounce
// Scan items update the debounce history and latch a key on press/release;
// read items return the latched key character.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                          tuser
// s_axis   in   cols_row0[2:0] cols_row1 cols_row2 cols_row3 mode
// m_axis   out  key_code[7:0] key_waiting key_missed         -
//
// One item per cycle sustained while the master side takes results; an input
// transfer passes the input register, then the result register. The state
// update sits between the two registers. Reset clears the engine state and
// empties both stages. A stalled master side holds the result; the input
// stage keeps taking items as long as the result register moves or is empty.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_latch_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cols_row0[2:0], cols_row1[5:3], cols_row2[8:6],
                                   // cols_row3[11:9], zero pad [15:12]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // key_code[7:0], key_waiting[8], key_missed[9],
                                   // zero pad [15:10]
);
    import kpsd_pkg::*;

    logic                          in_valid_reg;
    logic                          in_mode_reg;
    logic [ROWS-1:0][COL_BITS-1:0] in_cols_reg;
    logic                          out_valid_reg;
    kpsd_result_t                  out_result_reg;
    logic                          out_free;
    logic                          advance;
    kpsd_item_t                    item;
    kpsd_result_t                  result;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign item.fire = advance;
    assign item.mode = in_mode_reg;
    assign item.cols = in_cols_reg;

    kpsd_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser;
            in_cols_reg <= s_tdata[ROWS*COL_BITS-1:0];
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_result_reg.key_missed, out_result_reg.key_waiting,
                       out_result_reg.key_code};

endmodule
